// ===== design/fsscl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsscl_pkg: shared types and constants
// Phase encoding, status codes, register indexes and reset values for the
// slave-serial configuration loader.
// ----------------------------------------------------------------------------
package fsscl_pkg;

    // sequencer phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_INIT = 2'd1,
        PH_DATA = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    // run status codes
    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_BUSY       = 3'd1;
    localparam logic [2:0] ST_OK         = 3'd2;
    localparam logic [2:0] ST_DONE_STUCK = 3'd3;
    localparam logic [2:0] ST_NO_INIT    = 3'd4;
    localparam logic [2:0] ST_INIT_DATA  = 3'd5;
    localparam logic [2:0] ST_INIT_WAIT  = 3'd6;
    localparam logic [2:0] ST_TIMEOUT    = 3'd7;

    // input kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_WAIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DONE_WAIT = 8'd1;

    // register reset values
    localparam logic [15:0] INIT_WAIT_RST = 16'd100;
    localparam logic [15:0] DONE_WAIT_RST = 16'd1000;

    // bits per image byte
    localparam logic [3:0] BYTE_BITS = 4'd8;

endpackage : fsscl_pkg
`default_nettype wire

// ===== design/fpga_slave_serial_config_loader.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpga_slave_serial_config_loader: slave-serial configuration sequencer
// Each input beat is one tick of the configuration link. A start beat pulses
// PROG_B low; following ticks clock the device while waiting for INIT_B,
// shift image bytes MSB first, then wait for DONE and report a status code.
//
// Usage:
//   s_* channel: one beat per tick. tuser = kind (0 tick, 1 start),
//     tlast = byte_last, tdata = init_pin, done_pin, byte_valid, data_byte.
//   m_* channel: one result beat per input beat. tlast = finished (run
//     ended this tick), tdata = prog_drive, data_out, clock_pulse,
//     byte_taken, status.
//   cfg_* channel: register writes, index 0 init wait limit, 1 done wait
//     limit; other indexes are ignored. Write only while idle.
// The result beat is registered: it appears in the output register in the
// cycle after its input beat is taken. Throughput is one beat per cycle while
// the receiver does not stall, bounded by the phase sequencer's state update.
// When the receiver stalls, the result holds in the output register and the
// input side takes a new beat in the same cycle the held one is taken.
// Reset clears the sequencer to idle with status 0 and restores the wait
// limits to 100 and 1000.
// ----------------------------------------------------------------------------
module fpga_slave_serial_config_loader
    import fsscl_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input ticks
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [15:0]          s_tdata,   // init_pin, done_pin, byte_valid,
                                                 // data_byte[7:0], zero pad
    input  wire logic                 s_tuser,   // kind
    input  wire logic                 s_tlast,   // byte_last
    // results
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,   // prog_drive, data_out,
                                                 // clock_pulse, byte_taken,
                                                 // status[2:0], zero pad
    output logic                      m_tlast,   // finished
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    // input field unpack
    logic       in_init;
    logic       in_done;
    logic       in_bvalid;
    logic [7:0] in_byte;
    assign in_init   = s_tdata[0];
    assign in_done   = s_tdata[1];
    assign in_bvalid = s_tdata[2];
    assign in_byte   = s_tdata[10:3];

    // configuration registers
    logic [15:0] init_limit_reg;
    logic [15:0] done_limit_reg;

    // sequencer state
    phase_t      phase_reg,  phase_next;
    logic [15:0] wait_reg,   wait_next;
    logic [7:0]  shift_reg,  shift_next;
    logic [3:0]  bits_reg,   bits_next;
    logic        last_reg,   last_next;
    logic [2:0]  status_reg, status_next;

    // output register
    logic        m_valid_reg;
    logic [6:0]  m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;

    logic accept;
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // byte load into the shifter and the pulse it causes
    logic        load;
    logic [7:0]  cur_shift;
    logic [3:0]  cur_bits;
    logic [3:0]  bits_dec;
    logic        cur_last;
    logic [15:0] wait_inc;
    assign load      = (bits_reg == 4'd0) && in_bvalid;
    assign cur_shift = load ? in_byte : shift_reg;
    assign cur_bits  = load ? BYTE_BITS : bits_reg;
    assign cur_last  = load ? s_tlast : last_reg;
    assign bits_dec  = cur_bits - 4'd1;
    assign wait_inc  = wait_reg + 16'd1;

    // next state
    always_comb begin
        phase_next  = phase_reg;
        wait_next   = wait_reg;
        shift_next  = shift_reg;
        bits_next   = bits_reg;
        last_next   = last_reg;
        status_next = status_reg;
        if (s_tuser == KIND_START) begin
            phase_next  = PH_INIT;
            wait_next   = 16'd0;
            shift_next  = 8'd0;
            bits_next   = 4'd0;
            last_next   = 1'b0;
            status_next = ST_BUSY;
        end else begin
            unique case (phase_reg)
                PH_INIT: begin
                    wait_next = wait_inc;
                    if (in_init) begin
                        if (in_done) begin
                            phase_next  = PH_IDLE;
                            status_next = ST_DONE_STUCK;
                        end else begin
                            phase_next = PH_DATA;
                            wait_next  = 16'd0;
                        end
                    end else if (wait_inc >= init_limit_reg) begin
                        phase_next  = PH_IDLE;
                        status_next = in_done ? ST_DONE_STUCK : ST_NO_INIT;
                    end
                end
                PH_DATA: begin
                    shift_next = cur_shift;
                    bits_next  = cur_bits;
                    last_next  = cur_last;
                    if (cur_bits != 4'd0) begin
                        shift_next = {cur_shift[6:0], 1'b0};
                        bits_next  = bits_dec;
                        if (!in_init) begin
                            phase_next  = PH_IDLE;
                            status_next = ST_INIT_DATA;
                        end else if (bits_dec == 4'd0 && cur_last) begin
                            phase_next = PH_DONE;
                            wait_next  = 16'd0;
                        end
                    end
                end
                PH_DONE: begin
                    if (in_done) begin
                        phase_next  = PH_IDLE;
                        status_next = ST_OK;
                    end else if (!in_init) begin
                        phase_next  = PH_IDLE;
                        status_next = ST_INIT_WAIT;
                    end else begin
                        wait_next = wait_inc;
                        if (wait_inc >= done_limit_reg) begin
                            phase_next  = PH_IDLE;
                            status_next = ST_TIMEOUT;
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // result fields of this beat
    always_comb begin
        logic prog;
        logic dout;
        logic clk;
        logic taken;
        logic fin;
        prog  = 1'b1;
        dout  = 1'b0;
        clk   = 1'b0;
        taken = 1'b0;
        fin   = 1'b0;
        if (s_tuser == KIND_START) begin
            prog = 1'b0;
        end else begin
            unique case (phase_reg)
                PH_INIT: begin
                    clk = 1'b1;
                    fin = (in_init && in_done) ||
                          (!in_init && (wait_inc >= init_limit_reg));
                end
                PH_DATA: begin
                    taken = load;
                    if (cur_bits != 4'd0) begin
                        dout = cur_shift[7];
                        clk  = 1'b1;
                        fin  = !in_init;
                    end
                end
                PH_DONE: begin
                    fin = in_done || !in_init || (wait_inc >= done_limit_reg);
                end
                default: begin
                    fin = 1'b0;
                end
            endcase
        end
        m_data_next = {status_next, taken, clk, dout, prog};
        m_last_next = fin;
    end

    // sequencer and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            wait_reg       <= 16'd0;
            shift_reg      <= 8'd0;
            bits_reg       <= 4'd0;
            last_reg       <= 1'b0;
            status_reg     <= ST_IDLE;
            init_limit_reg <= INIT_WAIT_RST;
            done_limit_reg <= DONE_WAIT_RST;
        end else begin
            if (accept) begin
                phase_reg  <= phase_next;
                wait_reg   <= wait_next;
                shift_reg  <= shift_next;
                bits_reg   <= bits_next;
                last_reg   <= last_next;
                status_reg <= status_next;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_INIT_WAIT: init_limit_reg <= cfg_data;
                    REG_DONE_WAIT: done_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
            m_last_reg <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // a finished run reports a final code, never idle or busy
    a_fin_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_data_reg[6:4] >= ST_OK))
        else $error("finished beat without a final status code");

    // a start beat drives PROG_B low, reports busy and does not finish
    a_start_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg[0]) |-> (m_data_reg[6:4] == ST_BUSY && !m_last_reg))
        else $error("start beat with wrong status or finish flag");

    // a byte taken into the shifter starts shifting out on the same tick
    a_taken_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[3]) |-> m_data_reg[2])
        else $error("byte taken without a clock pulse");

    // an idle sequencer never holds the busy code
    a_idle_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (status_reg != ST_BUSY))
        else $error("idle phase with busy status");
`endif

endmodule : fpga_slave_serial_config_loader
`default_nettype wire

// ===== tb/fpga_slave_serial_config_loader_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpga_slave_serial_config_loader_tb: self-checking bench for the loader
// Drives tick beats into the sequencer and predicts every result beat with
// its own model of the slave-serial flow: PROG_B pulse, INIT_B wait, MSB
// first byte shifting and the DONE wait. Runs a short directed pass over
// four endings of a run, then shaped random runs under several wait limits,
// with bursty input, a patterned receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module fpga_slave_serial_config_loader_tb
    import fsscl_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;

    // one input tick and one result beat, as fields
    typedef struct packed {
        logic       kind;
        logic       init_pin;
        logic       done_pin;
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       byte_last;
    } tick_t;

    typedef struct packed {
        logic       prog_drive;
        logic       data_out;
        logic       clock_pulse;
        logic       byte_taken;
        logic [2:0] status;
        logic       finished;
    } tick_result_t;

    // predicts the sequencer and checks its result beats in order
    class loader_scoreboard;
        logic [15:0]  init_limit;
        logic [15:0]  done_limit;
        phase_t       phase;
        logic [15:0]  wait_cnt;
        logic [7:0]   shreg;
        logic [3:0]   bits_left;
        logic         last_seen;
        logic [2:0]   status;
        tick_result_t expected_ticks[$];
        int           errors;
        int           checked;
        int           run_ends[8];

        function new();
            init_limit = INIT_WAIT_RST;
            done_limit = DONE_WAIT_RST;
            phase      = PH_IDLE;
            wait_cnt   = '0;
            shreg      = '0;
            bits_left  = '0;
            last_seen  = 1'b0;
            status     = ST_IDLE;
            errors     = 0;
            checked    = 0;
            foreach (run_ends[i]) run_ends[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            if (idx == REG_INIT_WAIT) init_limit = val;
            else if (idx == REG_DONE_WAIT) done_limit = val;
        endfunction

        function void finish_run(logic [2:0] code, inout tick_result_t r);
            status     = code;
            phase      = PH_IDLE;
            r.finished = 1'b1;
            run_ends[code]++;
        endfunction

        // advance the model by one accepted tick
        function void note_tick(tick_t t);
            tick_result_t r;
            r = '0;
            r.prog_drive = 1'b1;
            if (t.kind == KIND_START) begin
                r.prog_drive = 1'b0;
                phase     = PH_INIT;
                wait_cnt  = '0;
                shreg     = '0;
                bits_left = '0;
                last_seen = 1'b0;
                status    = ST_BUSY;
            end else begin
                case (phase)
                    PH_INIT: begin
                        r.clock_pulse = 1'b1;
                        wait_cnt = wait_cnt + 16'd1;
                        if (t.init_pin) begin
                            if (t.done_pin) begin
                                finish_run(ST_DONE_STUCK, r);
                            end else begin
                                phase    = PH_DATA;
                                wait_cnt = '0;
                            end
                        end else if (wait_cnt >= init_limit) begin
                            finish_run(t.done_pin ? ST_DONE_STUCK : ST_NO_INIT, r);
                        end
                    end
                    PH_DATA: begin
                        if (bits_left == 0 && t.byte_valid) begin
                            shreg        = t.data_byte;
                            bits_left    = BYTE_BITS;
                            last_seen    = t.byte_last;
                            r.byte_taken = 1'b1;
                        end
                        // a tick with an empty shifter stalls without a pulse
                        if (bits_left != 0) begin
                            r.data_out    = shreg[7];
                            r.clock_pulse = 1'b1;
                            shreg         = shreg << 1;
                            bits_left     = bits_left - 4'd1;
                            if (!t.init_pin) begin
                                finish_run(ST_INIT_DATA, r);
                            end else if (bits_left == 0 && last_seen) begin
                                phase    = PH_DONE;
                                wait_cnt = '0;
                            end
                        end
                    end
                    PH_DONE: begin
                        if (t.done_pin) begin
                            finish_run(ST_OK, r);
                        end else if (!t.init_pin) begin
                            finish_run(ST_INIT_WAIT, r);
                        end else begin
                            wait_cnt = wait_cnt + 16'd1;
                            if (wait_cnt >= done_limit) finish_run(ST_TIMEOUT, r);
                        end
                    end
                    default: ;
                endcase
            end
            r.status = status;
            expected_ticks.push_back(r);
        endfunction

        function void compare_field(string name, logic [2:0] exp, logic [2:0] act);
            if (exp !== act) begin
                $display("%0t ns: mismatch on %s, expected %0d, actual %0d",
                         $time, name, exp, act);
                errors++;
            end
        endfunction

        // compare one accepted result beat with the oldest expectation
        function void check_tick(logic [7:0] data, logic fin);
            tick_result_t exp;
            if (expected_ticks.size() == 0) begin
                $display("%0t ns: result beat with no expectation, expected none, actual %h/%b",
                         $time, data, fin);
                errors++;
                return;
            end
            exp = expected_ticks.pop_front();
            checked++;
            compare_field("prog_drive", exp.prog_drive, data[0]);
            compare_field("data_out", exp.data_out, data[1]);
            compare_field("clock_pulse", exp.clock_pulse, data[2]);
            compare_field("byte_taken", exp.byte_taken, data[3]);
            compare_field("status", exp.status, data[6:4]);
            compare_field("finished", exp.finished, fin);
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;   // init_pin, done_pin, byte_valid,
                                            // data_byte[7:0], zero pad
    logic                 s_tuser   = 1'b0; // kind
    logic                 s_tlast   = 1'b0; // byte_last
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // prog_drive, data_out, clock_pulse,
                                            // byte_taken, status[2:0], zero pad
    logic                 m_tlast;          // finished
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    loader_scoreboard sb = new();
    int   beats_in     = 0;
    int   cycle_count  = 0;
    int   settings_run = 0;
    logic stall_hold   = 1'b0;

    // receiver pattern state
    int       ready_mode      = 0;
    int       ready_mode_left = 0;
    logic [7:0] ready_mask    = 8'hff;

    // random run shaping
    bit run_good    = 1'b1;
    int image_len   = 1;
    int bytes_given = 0;

    fpga_slave_serial_config_loader dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: patterned stalls, checking of every taken result beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_tick(m_tdata, m_tlast);
        if (ready_mode_left == 0) begin
            ready_mode      <= $urandom_range(0, 3);
            ready_mode_left <= $urandom_range(50, 250);
            ready_mask      <= 8'($urandom);
        end else begin
            ready_mode_left <= ready_mode_left - 1;
        end
        if (stall_hold) begin
            m_tready <= 1'b0;
        end else begin
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ready_mask[cycle_count[2:0]];
            endcase
        end
    end

    // long receiver hold-off while the sender keeps offering beats
    initial begin
        wait (beats_in >= 400);
        @(posedge aclk);
        stall_hold <= 1'b1;
        repeat (400) @(posedge aclk);
        stall_hold <= 1'b0;
    end

    // offer one tick beat and wait until it is taken
    task automatic offer(input tick_t t);
        s_tvalid <= 1'b1;
        s_tuser  <= t.kind;
        s_tlast  <= t.byte_last;
        s_tdata  <= {5'd0, t.data_byte, t.byte_valid, t.done_pin, t.init_pin};
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(t);
        beats_in++;
    endtask

    task automatic send_tick(input logic kind, input logic init, input logic done,
                             input logic bvalid, input logic [7:0] dbyte,
                             input logic blast);
        tick_t t;
        t = '{kind, init, done, bvalid, dbyte, blast};
        offer(t);
    endtask

    // wait until every result beat is back, plus a little slack
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_ticks.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limits(input logic [15:0] init_lim, input logic [15:0] done_lim);
        cfg_valid <= 1'b1;
        cfg_index <= REG_INIT_WAIT;
        cfg_data  <= init_lim;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(REG_INIT_WAIT, init_lim);
        cfg_index <= REG_DONE_WAIT;
        cfg_data  <= done_lim;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(REG_DONE_WAIT, done_lim);
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // next random tick, shaped by where the predicted sequencer is
    function automatic tick_t next_tick();
        tick_t t;
        t = '{1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1))};
        if (sb.phase == PH_IDLE) begin
            if ($urandom_range(0, 4) != 0) begin
                t.kind      = KIND_START;
                run_good    = ($urandom_range(0, 9) < 7);
                image_len   = $urandom_range(1, 4);
                bytes_given = 0;
            end
        end else if ($urandom_range(0, 99) == 0) begin
            // restart in the middle of a run
            t.kind      = KIND_START;
            image_len   = $urandom_range(1, 4);
            bytes_given = 0;
        end else if (!run_good && $urandom_range(0, 7) == 0) begin
            // pure noise tick
        end else begin
            case (sb.phase)
                PH_INIT: begin
                    t.init_pin = ($urandom_range(0, 2) == 0);
                    t.done_pin = ($urandom_range(0, 29) == 0);
                end
                PH_DATA: begin
                    t.init_pin   = run_good ? 1'b1 : ($urandom_range(0, 19) != 0);
                    t.byte_valid = ($urandom_range(0, 4) != 0);
                    if (sb.bits_left == 0 && t.byte_valid) begin
                        t.byte_last = run_good ? (bytes_given >= image_len - 1)
                                               : ($urandom_range(0, 3) == 0);
                        bytes_given++;
                    end
                end
                default: begin
                    t.done_pin = ($urandom_range(0, 3) == 0);
                    t.init_pin = run_good ? 1'b1 : ($urandom_range(0, 9) != 0);
                end
            endcase
        end
        return t;
    endfunction

    // bursts of ticks with random gaps, idle ticks not counted
    task automatic run_random(input int target);
        int    counted;
        int    burst;
        int    gap;
        tick_t t;
        counted = 0;
        while (counted < target) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 24);
            repeat (burst) begin
                t = next_tick();
                if (!(sb.phase == PH_IDLE && t.kind != KIND_START)) counted++;
                offer(t);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    initial begin
        logic [15:0] init_lims[6];
        logic [15:0] done_lims[6];
        init_lims = '{16'd100, 16'd1, 16'd0, 16'd65535, 16'd3, 16'd0};
        done_lims = '{16'd1000, 16'd1, 16'd0, 16'd65535, 16'd5, 16'd0};
        init_lims[5] = 16'($urandom_range(1, 16));
        done_lims[5] = 16'($urandom_range(1, 16));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed pass with short wait limits
        write_limits(16'd2, 16'd2);
        // tick while idle
        send_tick(KIND_TICK, 1'b1, 1'b1, 1'b1, 8'hff, 1'b1);
        // INIT_B rises with DONE already high
        send_tick(KIND_START, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        send_tick(KIND_TICK, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        // INIT_B never rises
        send_tick(KIND_START, 1'b1, 1'b1, 1'b1, 8'hff, 1'b1);
        send_tick(KIND_TICK, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        send_tick(KIND_TICK, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        // INIT_B drops during data
        send_tick(KIND_START, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        send_tick(KIND_TICK, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
        send_tick(KIND_TICK, 1'b1, 1'b0, 1'b1, 8'hff, 1'b0);
        send_tick(KIND_TICK, 1'b0, 1'b0, 1'b1, 8'h3c, 1'b1);
        // restart mid-run, stall tick, ignored bytes, then success
        send_tick(KIND_START, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        send_tick(KIND_START, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        send_tick(KIND_TICK, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
        send_tick(KIND_TICK, 1'b0, 1'b1, 1'b0, 8'h55, 1'b0);
        send_tick(KIND_TICK, 1'b1, 1'b0, 1'b1, 8'h81, 1'b1);
        for (int i = 0; i < 7; i++)
            send_tick(KIND_TICK, 1'b1, i[0], i[1], 8'(i * 37), i[0]);
        send_tick(KIND_TICK, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        // status holds after the run
        send_tick(KIND_TICK, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        drain();

        // random runs under each limit setting
        for (int p = 0; p < 6; p++) begin
            write_limits(init_lims[p], done_lims[p]);
            run_random(200);
            drain();
        end

        $display("%0d tick beats sent, %0d result beats checked, %0d limit settings",
                 beats_in, sb.checked, settings_run);
        $display("run endings: ok %0d, done stuck %0d, no init %0d, init lost %0d/%0d, timeout %0d",
                 sb.run_ends[ST_OK], sb.run_ends[ST_DONE_STUCK], sb.run_ends[ST_NO_INIT],
                 sb.run_ends[ST_INIT_DATA], sb.run_ends[ST_INIT_WAIT],
                 sb.run_ends[ST_TIMEOUT]);
        if (sb.errors == 0 && sb.expected_ticks.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/fsscl_pkg.sv
design/fpga_slave_serial_config_loader.sv
tb/fpga_slave_serial_config_loader_tb.sv
